[design/crlf_pkg.sv]
// ----------------------------------------------------------------------------
// crlf_pkg
// Shared types and constants for the line framer: operation codes, line
// delimiters, the result item layout and the response queue depth.
// ----------------------------------------------------------------------------
`default_nettype none

package crlf_pkg;

   typedef enum logic [1:0] {
      OP_RX_BYTE  = 2'd0,
      OP_ARM_DATA = 2'd1,
      OP_RELEASE  = 2'd2,
      OP_READ     = 2'd3
   } op_type;

   localparam logic [7:0] CHAR_CR = 8'h0D;
   localparam logic [7:0] CHAR_LF = 8'h0A;

   localparam int RSP_DEPTH = 3;

   typedef struct packed {
      logic       accepted;
      logic       echo_valid;
      logic [7:0] echo_byte;
      logic       message_valid;
      logic [1:0] message_buffer;
      logic [7:0] message_length;
      logic       message_is_data;
      logic [7:0] read_data;
   } rsp_type;

endpackage

`default_nettype wire

[design/crlf_ram.sv]
// ----------------------------------------------------------------------------
// crlf_ram
// Generic single-clock RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module crlf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[design/crlf_ctrl.sv]
// ----------------------------------------------------------------------------
// crlf_ctrl
// Framer control: buffer pool, line / data mode tracking and the buffer
// store. Updates state in the accept cycle; the result leaves in the cycle
// after, together with the registered store read.
// ----------------------------------------------------------------------------
`default_nettype none

module crlf_ctrl import crlf_pkg::*; #(
   parameter int BUFFER_COUNT = 4,
   parameter int BUFFER_BYTES = 256
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       csr_write_enable,
   input  wire logic       csr_write_data,
   input  wire logic       accept,
   input  wire logic [1:0] operation,
   input  wire logic [7:0] rx_byte,
   input  wire logic [7:0] data_length,
   input  wire logic [1:0] buffer_index,
   input  wire logic [7:0] read_offset,
   output logic            rsp_valid,
   output rsp_type         rsp
);

   localparam int BUF_W  = (BUFFER_COUNT > 1) ? $clog2(BUFFER_COUNT) : 1;
   localparam int OFF_W  = $clog2(BUFFER_BYTES);
   localparam int DEPTH  = BUFFER_COUNT * (1 << OFF_W);
   localparam int ADDR_W = $clog2(DEPTH);
   localparam logic [8:0] LINE_LIMIT = 9'(BUFFER_BYTES - 1);
   localparam logic [8:0] BYTES_LIM  = 9'(BUFFER_BYTES);
   localparam logic [3:0] COUNT_LIM  = 4'(BUFFER_COUNT);

   logic                    echo_enable_ff;
   logic [BUFFER_COUNT-1:0] pool_busy_ff, pool_busy_in;
   logic                    have_buffer_ff, have_buffer_in;
   logic [BUF_W-1:0]        current_buffer_ff, current_buffer_in;
   logic [7:0]              line_count_ff, line_count_in;
   logic [7:0]              last_byte_ff, last_byte_in;
   logic [7:0]              data_target_ff, data_target_in;
   logic [7:0]              data_count_ff, data_count_in;
   logic                    s1_valid_ff;
   logic                    s1_read_ff, s1_read_in;
   rsp_type                 s1_rsp_ff, s1_rsp_in;

   logic              free_found;
   logic [BUF_W-1:0]  free_idx;
   logic [BUF_W-1:0]  buf_sel;
   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic [7:0]        wr_pos;
   logic              rd_en;
   logic [ADDR_W-1:0] rd_addr;
   logic [7:0]        rd_data;
   logic              line_ends;
   logic [7:0]        line_len;
   logic [7:0]        data_next;

   always_comb begin
      free_found = 1'b0;
      free_idx   = '0;
      for (int i = BUFFER_COUNT - 1; i >= 0; i--) begin
         if (!pool_busy_ff[i]) begin
            free_found = 1'b1;
            free_idx   = BUF_W'(i);
         end
      end
   end

   assign buf_sel   = have_buffer_ff ? current_buffer_ff : free_idx;
   assign line_ends = (line_count_ff != 8'd0) && (last_byte_ff == CHAR_CR) &&
                      (rx_byte == CHAR_LF);
   assign line_len  = line_count_ff - 8'd1;
   assign data_next = data_count_ff + 8'd1;
   assign wr_addr   = (ADDR_W'(buf_sel) << OFF_W) | ADDR_W'(wr_pos[OFF_W-1:0]);
   assign rd_addr   = (ADDR_W'(buffer_index) << OFF_W) |
                      ADDR_W'(read_offset[OFF_W-1:0]);

   always_comb begin
      pool_busy_in      = pool_busy_ff;
      have_buffer_in    = have_buffer_ff;
      current_buffer_in = current_buffer_ff;
      line_count_in     = line_count_ff;
      last_byte_in      = last_byte_ff;
      data_target_in    = data_target_ff;
      data_count_in     = data_count_ff;
      s1_rsp_in         = '0;
      s1_read_in        = 1'b0;
      wr_en             = 1'b0;
      wr_pos            = line_count_ff;
      rd_en             = 1'b0;
      if (accept) begin
         case (op_type'(operation))
            OP_RX_BYTE: begin
               if (have_buffer_ff || free_found) begin
                  s1_rsp_in.accepted = 1'b1;
                  if (!have_buffer_ff) begin
                     have_buffer_in    = 1'b1;
                     current_buffer_in = free_idx;
                     for (int i = 0; i < BUFFER_COUNT; i++) begin
                        if (BUF_W'(i) == free_idx) begin
                           pool_busy_in[i] = 1'b1;
                        end
                     end
                  end
                  if (data_target_ff == 8'd0) begin
                     s1_rsp_in.echo_valid = echo_enable_ff;
                     s1_rsp_in.echo_byte  = echo_enable_ff ? rx_byte : 8'd0;
                     if ({1'b0, line_count_ff} < LINE_LIMIT) begin
                        wr_en        = 1'b1;
                        last_byte_in = rx_byte;
                        if (line_ends) begin
                           line_count_in = 8'd0;
                           if (line_len != 8'd0) begin
                              s1_rsp_in.message_valid  = 1'b1;
                              s1_rsp_in.message_buffer = 2'(buf_sel);
                              s1_rsp_in.message_length = line_len;
                              have_buffer_in           = 1'b0;
                           end
                        end else begin
                           line_count_in = line_count_ff + 8'd1;
                        end
                     end else begin
                        line_count_in = 8'd0;
                     end
                  end else begin
                     wr_pos = data_count_ff;
                     wr_en  = ({1'b0, data_count_ff} < BYTES_LIM);
                     if (data_next == data_target_ff) begin
                        s1_rsp_in.message_valid   = 1'b1;
                        s1_rsp_in.message_buffer  = 2'(buf_sel);
                        s1_rsp_in.message_length  = data_target_ff;
                        s1_rsp_in.message_is_data = 1'b1;
                        data_target_in            = 8'd0;
                        data_count_in             = 8'd0;
                        have_buffer_in            = 1'b0;
                     end else begin
                        data_count_in = data_next;
                     end
                  end
               end
            end
            OP_ARM_DATA: begin
               data_target_in = data_length;
               data_count_in  = 8'd0;
            end
            OP_RELEASE: begin
               for (int i = 0; i < BUFFER_COUNT; i++) begin
                  if (4'(i) == {2'b00, buffer_index}) begin
                     pool_busy_in[i] = 1'b0;
                  end
               end
            end
            OP_READ: begin
               if (({2'b00, buffer_index} < COUNT_LIM) &&
                   ({1'b0, read_offset} < BYTES_LIM)) begin
                  rd_en      = 1'b1;
                  s1_read_in = 1'b1;
               end
            end
            default: begin
               s1_rsp_in = '0;
            end
         endcase
      end
   end

   crlf_ram #(
      .WIDTH (8),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (rx_byte),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         echo_enable_ff    <= 1'b1;
         pool_busy_ff      <= '0;
         have_buffer_ff    <= 1'b0;
         current_buffer_ff <= '0;
         line_count_ff     <= 8'd0;
         last_byte_ff      <= 8'd0;
         data_target_ff    <= 8'd0;
         data_count_ff     <= 8'd0;
         s1_valid_ff       <= 1'b0;
         s1_read_ff        <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            echo_enable_ff <= csr_write_data;
         end
         pool_busy_ff      <= pool_busy_in;
         have_buffer_ff    <= have_buffer_in;
         current_buffer_ff <= current_buffer_in;
         line_count_ff     <= line_count_in;
         last_byte_ff      <= last_byte_in;
         data_target_ff    <= data_target_in;
         data_count_ff     <= data_count_in;
         s1_valid_ff       <= accept;
         s1_read_ff        <= s1_read_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_rsp_ff <= s1_rsp_in;
   end

   always_comb begin
      rsp           = s1_rsp_ff;
      rsp.read_data = s1_read_ff ? rd_data : 8'd0;
   end

   assign rsp_valid = s1_valid_ff;

   // a completed message or an echo always comes from an accepted byte
   assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && (s1_rsp_ff.message_valid || s1_rsp_ff.echo_valid)
         |-> s1_rsp_ff.accepted)
      else $error("message or echo without an accepted byte");

   // a byte that gets a buffer always leaves one in hand or completes a message
   assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && s1_rsp_ff.accepted && !s1_rsp_ff.message_valid
         |-> have_buffer_ff)
      else $error("accepted byte left no buffer in hand");

   // a store read never coincides with a stored byte
   assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && s1_read_ff |-> !s1_rsp_ff.accepted)
      else $error("read and receive in one item");

endmodule

`default_nettype wire

[design/crlf_rsp_fifo.sv]
// ----------------------------------------------------------------------------
// crlf_rsp_fifo
// Small result queue between the framer pipeline and the response channel.
// ----------------------------------------------------------------------------
`default_nettype none

module crlf_rsp_fifo import crlf_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire rsp_type push_data,
   input  wire logic    pop,
   output logic         head_valid,
   output rsp_type      head_data,
   output logic [1:0]   count
);

   localparam logic [1:0] LAST = 2'(RSP_DEPTH - 1);

   rsp_type    entry_ff [RSP_DEPTH];
   logic [1:0] wr_ptr_ff, wr_ptr_in;
   logic [1:0] rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST) ? 2'd0 : wr_ptr_ff + 2'd1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST) ? 2'd0 : rd_ptr_ff + 2'd1;
      end
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 2'd0;
         rd_ptr_ff <= 2'd0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign head_valid = (count_ff != 2'd0);
   assign head_data  = entry_ff[rd_ptr_ff];
   assign count      = count_ff;

   assert property (@(posedge clock) disable iff (reset)
      push && !pop |-> count_ff != 2'(RSP_DEPTH))
      else $error("result queue overflow");

   assert property (@(posedge clock) disable iff (reset)
      pop |-> count_ff != 2'd0)
      else $error("result queue underflow");

endmodule

`default_nettype wire

[design/crlf_line_framer_with_buffer_pool.sv]
// ----------------------------------------------------------------------------
// crlf_line_framer_with_buffer_pool
// Serial receive line framer with a pool of receive buffers.
// ----------------------------------------------------------------------------
// Takes one item per clock while req_ready is high. Each item updates the
// framer state in the cycle it is accepted; its result is registered in the
// control stage with the registered read of the buffer store RAM (a single
// write port for received bytes, a single read port for buffer reads), then
// leaves through a three-entry result queue that keeps the input flowing
// while results wait. The store is not cleared after reset; read only bytes
// that were written. Echo is enabled after reset.
`default_nettype none

module crlf_line_framer_with_buffer_pool import crlf_pkg::*; #(
   parameter int BUFFER_COUNT = 4,
   parameter int BUFFER_BYTES = 256
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       csr_write_enable,
   input  wire logic       csr_write_data,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [1:0] req_operation,
   input  wire logic [7:0] req_rx_byte,
   input  wire logic [7:0] req_data_length,
   input  wire logic [1:0] req_buffer_index,
   input  wire logic [7:0] req_read_offset,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic            rsp_accepted,
   output logic            rsp_echo_valid,
   output logic [7:0]      rsp_echo_byte,
   output logic            rsp_message_valid,
   output logic [1:0]      rsp_message_buffer,
   output logic [7:0]      rsp_message_length,
   output logic            rsp_message_is_data,
   output logic [7:0]      rsp_read_data
);

   logic       accept;
   logic       s1_valid;
   rsp_type    s1_rsp;
   rsp_type    head;
   logic [1:0] queue_count;
   logic [2:0] in_flight;

   assign in_flight = {1'b0, queue_count} + {2'b00, s1_valid};
   assign req_ready = (in_flight < 3'(RSP_DEPTH));
   assign accept    = req_valid && req_ready;

   crlf_ctrl #(
      .BUFFER_COUNT (BUFFER_COUNT),
      .BUFFER_BYTES (BUFFER_BYTES)
   ) u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .accept           (accept),
      .operation        (req_operation),
      .rx_byte          (req_rx_byte),
      .data_length      (req_data_length),
      .buffer_index     (req_buffer_index),
      .read_offset      (req_read_offset),
      .rsp_valid        (s1_valid),
      .rsp              (s1_rsp)
   );

   crlf_rsp_fifo u_rsp_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (s1_valid),
      .push_data  (s1_rsp),
      .pop        (rsp_valid && rsp_ready),
      .head_valid (rsp_valid),
      .head_data  (head),
      .count      (queue_count)
   );

   assign rsp_accepted        = head.accepted;
   assign rsp_echo_valid      = head.echo_valid;
   assign rsp_echo_byte       = head.echo_byte;
   assign rsp_message_valid   = head.message_valid;
   assign rsp_message_buffer  = head.message_buffer;
   assign rsp_message_length  = head.message_length;
   assign rsp_message_is_data = head.message_is_data;
   assign rsp_read_data       = head.read_data;

   assert property (@(posedge clock) disable iff (reset)
      in_flight <= 3'(RSP_DEPTH))
      else $error("more items in flight than queue slots");

endmodule

`default_nettype wire
